// File: src/lrup_pkg.sv
// Shared constants and types for the LRU page replacement block.
// No dependencies; imported by lru_page_replacement.
`default_nettype none

package lrup_pkg;

  // Frame store geometry and field widths
  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_W    = 3;
  localparam int CNT_W      = 4;
  localparam int FAULT_W    = 32;

  localparam logic [CNT_W-1:0]   FRAMES_CNT = CNT_W'(FRAMES);
  localparam logic [CNT_W-1:0]   LIMIT_RST  = CNT_W'(8);
  localparam logic [FAULT_W-1:0] FAULT_MAX  = '1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_W-1:0]   rank_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_VICTIM,
    ST_UPDATE
  } lrup_state_t;

endpackage

`default_nettype wire

// File: src/lru_page_replacement.sv
// LRU page replacement over a fully associative set of frames.
// Each accepted item runs a search over the filled frames, a victim scan on a
// full miss only, and an update that commits state and loads the result. A new
// item is taken only in idle, after the last one has been committed; the single
// shared page and rank comparators step one frame per cycle. A stalled result
// holds the update state. Reset (synchronous, rst_n low): no frames, faults zero, limit 8.
`default_nettype none

module lru_page_replacement
  import lrup_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CNT_W-1:0]     cfg_frames_in_use,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PAGE_BITS-1:0] in_page,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hit,
  output logic [FRAME_W-1:0]        out_frame,
  output logic                      out_evicted_valid,
  output logic [PAGE_BITS-1:0]      out_evicted_page,
  output logic [FAULT_W-1:0]        out_fault_count
);

  // Page store: written only when filled or replaced, no reset
  page_t frame_pages [FRAMES];

  lrup_state_t state_r, state_nxt;
  cnt_t        limit_r, limit_nxt;       // configured frames_in_use
  cnt_t        lim_r, lim_nxt;           // clamped limit latched per item
  cnt_t        searched_r, searched_nxt;
  cnt_t        filled_r, filled_nxt;
  cnt_t        idx_r, idx_nxt;
  cnt_t        best_r, best_nxt;
  rank_t       best_rank_r, best_rank_nxt;
  page_t       page_r, page_nxt;
  logic        hit_r, hit_nxt;
  logic        fill_r, fill_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  rank_t       ranks_r [FRAMES];
  rank_t       ranks_nxt [FRAMES];

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_ev_r, out_ev_nxt;
  page_t              out_ev_page_r, out_ev_page_nxt;
  logic [FAULT_W-1:0] out_fault_r, out_fault_nxt;

  logic       in_acc;
  logic       out_free;
  logic       cfg_acc;
  cnt_t       clamp_lim;
  page_t      pg_rd_r;
  rank_t      rank_rd;
  logic       in_range;
  logic       page_match;
  logic       commit;
  logic       pg_we;
  cnt_t       filled_new;
  cnt_t       old_rank;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_UPDATE) && out_free;
  assign pg_we     = commit && !hit_r;

  // Clamp the configured limit into 1..FRAMES
  always_comb begin
    if (limit_r == '0) begin
      clamp_lim = CNT_W'(1);
    end else if (limit_r > FRAMES_CNT) begin
      clamp_lim = FRAMES_CNT;
    end else begin
      clamp_lim = limit_r;
    end
  end

  // Shared comparators, all addressed by the step counter
  assign rank_rd    = ranks_r[idx_r[FRAME_W-1:0]];
  assign in_range   = (idx_r < searched_r);
  assign page_match = (pg_rd_r == page_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (in_range) begin
          if (page_match) state_nxt = ST_UPDATE;
        end else if (filled_r < lim_r) begin
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        if (idx_r >= lim_r) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Rank update inputs: a fill ages every other filled frame
  assign filled_new = filled_r + CNT_W'(fill_r);
  assign old_rank   = fill_r ? FRAMES_CNT : {1'b0, rank_rd};

  // Datapath and result next values
  always_comb begin
    limit_nxt     = cfg_acc ? cfg_frames_in_use : limit_r;
    lim_nxt       = lim_r;
    searched_nxt  = searched_r;
    filled_nxt    = filled_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    best_rank_nxt = best_rank_r;
    page_nxt      = page_r;
    hit_nxt       = hit_r;
    fill_nxt      = fill_r;
    fault_nxt     = fault_r;
    for (int i = 0; i < FRAMES; i++) begin
      ranks_nxt[i] = ranks_r[i];
    end
    out_valid_nxt   = out_valid_r && out_stall;
    out_hit_nxt     = out_hit_r;
    out_frame_nxt   = out_frame_r;
    out_ev_nxt      = out_ev_r;
    out_ev_page_nxt = out_ev_page_r;
    out_fault_nxt   = out_fault_r;

    case (state_r)
      // Latch the item and the search bound
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt     = in_page;
          lim_nxt      = clamp_lim;
          searched_nxt = (filled_r < clamp_lim) ? filled_r : clamp_lim;
          idx_nxt      = '0;
          hit_nxt      = 1'b0;
          fill_nxt     = 1'b0;
        end
      end
      // Compare one filled frame per cycle; on a miss pick fill or scan
      ST_SEARCH: begin
        if (in_range) begin
          if (page_match) begin
            hit_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end else if (filled_r < lim_r) begin
          fill_nxt = 1'b1;
          idx_nxt  = filled_r;
        end else begin
          best_nxt      = '0;
          best_rank_nxt = ranks_r[0];
          idx_nxt       = CNT_W'(1);
        end
      end
      // Scan ranks for the oldest frame; lowest index wins ties
      ST_VICTIM: begin
        if (idx_r < lim_r) begin
          if (rank_rd > best_rank_r) begin
            best_nxt      = idx_r;
            best_rank_nxt = rank_rd;
          end
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          idx_nxt = best_r;
        end
      end
      // Commit state and load the result register
      ST_UPDATE: begin
        if (out_free) begin
          filled_nxt = filled_new;
          if (!hit_r && (fault_r != FAULT_MAX)) begin
            fault_nxt = fault_r + FAULT_W'(1);
          end
          for (int i = 0; i < FRAMES; i++) begin
            if (CNT_W'(i) == idx_r) begin
              ranks_nxt[i] = '0;
            end else if ((CNT_W'(i) < filled_new) && ({1'b0, ranks_r[i]} < old_rank)) begin
              ranks_nxt[i] = ranks_r[i] + FRAME_W'(1);
            end
          end
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = hit_r;
          out_frame_nxt   = idx_r[FRAME_W-1:0];
          out_ev_nxt      = !hit_r && !fill_r;
          out_ev_page_nxt = (!hit_r && !fill_r) ? pg_rd_r : '0;
          out_fault_nxt   = (!hit_r && (fault_r != FAULT_MAX)) ?
                            fault_r + FAULT_W'(1) : fault_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RST;
      filled_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        ranks_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      filled_r    <= filled_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < FRAMES; i++) begin
        ranks_r[i] <= ranks_nxt[i];
      end
    end
    lim_r         <= lim_nxt;
    searched_r    <= searched_nxt;
    idx_r         <= idx_nxt;
    best_r        <= best_nxt;
    best_rank_r   <= best_rank_nxt;
    page_r        <= page_nxt;
    hit_r         <= hit_nxt;
    fill_r        <= fill_nxt;
    out_hit_r     <= out_hit_nxt;
    out_frame_r   <= out_frame_nxt;
    out_ev_r      <= out_ev_nxt;
    out_ev_page_r <= out_ev_page_nxt;
    out_fault_r   <= out_fault_nxt;
  end

  // Page store write on fill or replacement; read the next step's frame
  always_ff @(posedge clk) begin
    if (pg_we) begin
      frame_pages[idx_r[FRAME_W-1:0]] <= page_r;
    end
    pg_rd_r <= frame_pages[idx_nxt[FRAME_W-1:0]];
  end

  // Result ports
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_fault_r;

  // Filled count never passes the frame store size
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= FRAMES_CNT)
    else $error("filled count exceeds frame count");

  // A victim scan only runs when every frame under the limit is filled
  a_victim_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_VICTIM |-> filled_r >= lim_r)
    else $error("victim scan with free frames");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_ev_r)
    else $error("eviction reported on hit");

  // Fault total never decreases
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fault_r >= $past(fault_r))
    else $error("fault total decreased");

endmodule

`default_nettype wire

// File: test/tb_lru_page_replacement.sv
// Testbench for lru_page_replacement: drives page references and frame limits,
// predicts every result with a frame tracker and checks it. Needs lrup_pkg and
// lru_page_replacement only.
`timescale 1ns / 100ps

module tb_lru_page_replacement;
  import lrup_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int GAP_PERCENT    = 37;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               ev_valid;
    page_t              ev_page;
    logic [FAULT_W-1:0] faults;
  } page_result_t;

  // Tracks frame contents and recency, and holds the results still to come
  class frame_tracker;
    page_t              pages[FRAMES];
    int                 ranks[FRAMES];
    int                 filled;
    logic [FAULT_W-1:0] faults;
    cnt_t               limit_code;
    page_result_t       pending_results[$];
    int                 errors;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        pages[i] = '0;
        ranks[i] = 0;
      end
      filled     = 0;
      faults     = '0;
      limit_code = LIMIT_RST;
      errors     = 0;
    endfunction

    function void set_limit(cnt_t code);
      limit_code = code;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    // Make frame f the newest; filled frames younger than its old rank age by one
    function void promote(int f, int old_rank);
      for (int i = 0; i < filled; i++) begin
        if (i != f && ranks[i] < old_rank) ranks[i]++;
      end
      ranks[f] = 0;
    endfunction

    // Predict the result of one accepted page reference
    function void note_reference(page_t p);
      int           lim;
      int           searched;
      int           f;
      int           best;
      bit           found;
      page_result_t r;
      lim = int'(limit_code);
      if (lim < 1) lim = 1;
      if (lim > FRAMES) lim = FRAMES;
      searched = (filled < lim) ? filled : lim;
      found = 1'b0;
      f = 0;
      r = '0;
      // search only filled frames below the current limit
      for (int i = 0; i < searched; i++) begin
        if (!found && pages[i] == p) begin
          found = 1'b1;
          f = i;
        end
      end
      if (found) begin
        promote(f, ranks[f]);
      end else begin
        if (faults != FAULT_MAX) faults++;
        if (filled < lim) begin
          // fill the next empty frame
          f = filled;
          pages[f] = p;
          filled++;
          promote(f, FRAMES);
        end else begin
          // replace the oldest frame; lowest index wins a tie
          best = 0;
          for (int i = 1; i < lim; i++) begin
            if (ranks[i] > ranks[best]) best = i;
          end
          f = best;
          r.ev_valid = 1'b1;
          r.ev_page  = pages[f];
          pages[f]   = p;
          promote(f, ranks[f]);
        end
      end
      r.hit    = found;
      r.frame  = f[FRAME_W-1:0];
      r.faults = faults;
      pending_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_outcome(page_result_t got);
      page_result_t want;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: hit=%0b frame=%0d ev=%0b evp=%h faults=%0d",
                             got.hit, got.frame, got.ev_valid, got.ev_page, got.faults));
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit || got.frame !== want.frame ||
          got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page ||
          got.faults !== want.faults) begin
        note_error($sformatf({"mismatch: exp hit=%0b frame=%0d ev=%0b evp=%h faults=%0d,",
                              " got hit=%0b frame=%0d ev=%0b evp=%h faults=%0d"},
                             want.hit, want.frame, want.ev_valid, want.ev_page, want.faults,
                             got.hit, got.frame, got.ev_valid, got.ev_page, got.faults));
      end
    endfunction

    function void close_out();
      if (pending_results.size() != 0)
        note_error($sformatf("%0d results never arrived", pending_results.size()));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_frames_in_use;
  logic                 in_valid;
  logic                 in_stall;
  logic [PAGE_BITS-1:0] in_page;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit;
  logic [FRAME_W-1:0]   out_frame;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;
  logic [FAULT_W-1:0]   out_fault_count;

  frame_tracker tracker;
  bit           gaps_on = 1'b1;
  page_t        last_pool[$];

  lru_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame         (out_frame),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random while gaps are enabled
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
    end
  end

  // Observe every handshake at the clock edge
  always @(posedge clk) begin : monitor
    page_result_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.set_limit(cfg_frames_in_use);
      if (in_valid && !in_stall) tracker.note_reference(in_page);
      if (out_valid && !out_stall) begin
        seen.hit      = out_hit;
        seen.frame    = out_frame;
        seen.ev_valid = out_evicted_valid;
        seen.ev_page  = out_evicted_page;
        seen.faults   = out_fault_count;
        tracker.check_outcome(seen);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_lru_page_replacement: done, errors");
    $finish;
  end

  // Present one page, idling first at random, and hold it until accepted
  task automatic push_page(input page_t p);
    while (gaps_on && ($urandom_range(99) < GAP_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page  <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain all results, then write the frame limit
  task automatic write_limit(input cnt_t code);
    // step past the last accept so the monitor has noted it
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_frames_in_use <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One limit setting, then references mostly drawn from a small working set
  task automatic random_phase(input cnt_t code, input int count);
    page_t pool[$];
    page_t p;
    int    eff;
    int    pool_size;
    int    pick;
    eff = (code == 0) ? 1 : ((int'(code) > FRAMES) ? FRAMES : int'(code));
    write_limit(code);
    pool_size = eff + $urandom_range(3);
    for (int i = 0; i < pool_size; i++) pool.push_back(page_t'($urandom));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 80)
        p = pool[$urandom_range(pool_size - 1)];
      else if (pick < 92 && last_pool.size() > 0)
        p = last_pool[$urandom_range(last_pool.size() - 1)];
      else
        p = page_t'($urandom);
      push_page(p);
    end
    in_valid <= 1'b0;
    last_pool = pool;
  endtask

  initial begin : stimulus
    cnt_t codes[12];
    codes = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd9, 4'd3, 4'd7, 4'd4, 4'd6, 4'd8};
    tracker = new();
    rst_n             <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_frames_in_use <= '0;
    in_valid          <= 1'b0;
    in_page           <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill all eight frames from reset, hit, then evict the oldest twice
    push_page(16'h0000);
    push_page(16'hFFFF);
    push_page(16'h0000);
    push_page(16'h0001);
    push_page(16'h8000);
    push_page(16'h5555);
    push_page(16'hAAAA);
    push_page(16'h00FF);
    push_page(16'hFF00);
    push_page(16'h1234);
    push_page(16'hFFFF);
    in_valid <= 1'b0;

    // zero limit acts as a single frame
    write_limit(4'd0);
    push_page(16'h1234);
    push_page(16'h4321);
    push_page(16'h4321);
    in_valid <= 1'b0;

    // lowered limit: upper frames are neither searched nor replaced
    write_limit(4'd3);
    push_page(16'h00FF);
    push_page(16'h7777);
    in_valid <= 1'b0;

    // limit above the frame count acts as all frames; upper pages hit again
    write_limit(4'd15);
    push_page(16'hAAAA);
    push_page(16'hFF00);
    push_page(16'h5555);
    in_valid <= 1'b0;

    // random phases over many limits, with one stretch free of gaps
    for (int k = 0; k < 13; k++) begin
      gaps_on = !(k == 4 || k == 5);
      if (k < 12)
        random_phase(codes[k], 95);
      else
        random_phase(cnt_t'($urandom_range(15)), 95);
    end
    gaps_on = 1'b1;

    // let the last results come out
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0)
      $display("tb_lru_page_replacement: done, clean");
    else
      $display("tb_lru_page_replacement: done, errors");
    $finish;
  end

endmodule

// File: sim.f
src/lrup_pkg.sv
src/lru_page_replacement.sv
test/tb_lru_page_replacement.sv
